// ----- rtl/cwpf_pkg.sv -----
`timescale 1ns / 1ps
package cwpf_pkg;

	localparam int COORD_BITS = 12;
	localparam int CFG_DATA_BITS = 16;
	localparam int NUM_STEPS = 11;

	// byte slots of one command, sent in ascending order
	localparam int STEP_SYNC_A = 0;
	localparam int STEP_SYNC_B = 1;
	localparam int STEP_TYPE = 2;
	localparam int STEP_W_HI = 3;
	localparam int STEP_W_LO = 4;
	localparam int STEP_H_HI = 5;
	localparam int STEP_H_LO = 6;
	localparam int STEP_PIX_HI = 7;
	localparam int STEP_PIX_LO = 8;
	localparam int STEP_TRL_A = 9;
	localparam int STEP_TRL_B = 10;

	localparam logic [7:0] BYTE_AA = 8'hAA;
	localparam logic [7:0] BYTE_55 = 8'h55;
	localparam logic [7:0] TYPE_BIN = 8'd7;
	localparam logic [7:0] TYPE_RAW = 8'd8;

	typedef enum logic [2:0] {
		CFG_LEFT_COL = 3'd0,
		CFG_TOP_ROW = 3'd1,
		CFG_RIGHT_COL = 3'd2,
		CFG_BOTTOM_ROW = 3'd3,
		CFG_SEND_RAW = 3'd4,
		CFG_BIN_THRESHOLD = 3'd5
	} cfg_idx_t;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [NUM_STEPS-1:0] step_mask_t;

	typedef struct packed {
		logic [15:0] pixel;
		coord_t col;
		coord_t row;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_of_run;
		logic frame_done;
	} byte_out_t;

	typedef struct packed {
		coord_t left_col;
		coord_t top_row;
		coord_t right_col;
		coord_t bottom_row;
		logic send_raw;
		logic [15:0] bin_threshold;
	} cfg_t;

	typedef struct packed {
		step_mask_t mask;
		logic raw;
		logic [15:0] data;
	} cmd_t;

endpackage

// ----- rtl/cwpf_front.sv -----
`timescale 1ns / 1ps
module cwpf_front (
	input logic clk,
	input logic arst_n,
	input cwpf_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_stall,
	input cwpf_pkg::pix_in_t in_item,
	input logic cmd_full,
	output logic cmd_push,
	output cwpf_pkg::cmd_t cmd
);

	logic [7:0] packed_q;
	logic in_win, hdr, trl, emit, hit, accept;
	logic [2:0] place;
	logic [7:0] base, nxt;
	cwpf_pkg::coord_t offs;

	assign in_stall = cmd_full;
	assign accept = in_valid && !cmd_full;

	always_comb begin
		in_win = (in_item.col >= cfg.left_col) && (in_item.col <= cfg.right_col) &&
			(in_item.row >= cfg.top_row) && (in_item.row <= cfg.bottom_row);
		hdr = (in_item.col == cfg.left_col) && (in_item.row == cfg.top_row);
		trl = (in_item.col == cfg.right_col) && (in_item.row == cfg.bottom_row);
		offs = in_item.col - cfg.left_col;
		place = offs[2:0];
		base = (place == 3'd0) ? 8'd0 : packed_q;
		hit = in_item.pixel > cfg.bin_threshold;
		nxt = base | ({7'd0, hit} << (3'd7 - place));
		emit = (place == 3'd7) || (in_item.col == cfg.right_col);

		cmd.mask = '0;
		cmd.mask[cwpf_pkg::STEP_SYNC_A] = hdr;
		cmd.mask[cwpf_pkg::STEP_SYNC_B] = hdr;
		cmd.mask[cwpf_pkg::STEP_TYPE] = hdr;
		cmd.mask[cwpf_pkg::STEP_W_HI] = hdr;
		cmd.mask[cwpf_pkg::STEP_W_LO] = hdr;
		cmd.mask[cwpf_pkg::STEP_H_HI] = hdr;
		cmd.mask[cwpf_pkg::STEP_H_LO] = hdr;
		cmd.mask[cwpf_pkg::STEP_PIX_HI] = cfg.send_raw;
		cmd.mask[cwpf_pkg::STEP_PIX_LO] = cfg.send_raw || emit;
		cmd.mask[cwpf_pkg::STEP_TRL_A] = trl;
		cmd.mask[cwpf_pkg::STEP_TRL_B] = trl;
		cmd.raw = cfg.send_raw;
		cmd.data = cfg.send_raw ? in_item.pixel : {8'd0, nxt};
	end

	// drop out-of-window pixels and bit-only pixels that finish no byte
	assign cmd_push = accept && in_win && (cmd.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packed_q <= 8'd0;
		end else if (accept && in_win && !cfg.send_raw) begin
			packed_q <= emit ? 8'd0 : nxt;
		end
	end

endmodule

// ----- rtl/cwpf_cmd_fifo.sv -----
`timescale 1ns / 1ps
module cwpf_cmd_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cwpf_pkg::cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic head_valid,
	output cwpf_pkg::cmd_t head_cmd
);

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	cwpf_pkg::cmd_t slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == (PTR_BITS+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/cwpf_back.sv -----
`timescale 1ns / 1ps
module cwpf_back (
	input logic clk,
	input logic arst_n,
	input cwpf_pkg::cfg_t cfg,
	input logic head_valid,
	input cwpf_pkg::cmd_t head_cmd,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output cwpf_pkg::byte_out_t out_item
);

	cwpf_pkg::step_mask_t mask_q, low_bit, rest;
	logic [15:0] data_q;
	logic raw_q, out_valid_q;
	cwpf_pkg::byte_out_t out_q;
	logic slot_free, have, emit, last;
	logic [3:0] idx;
	logic [15:0] width, height;
	logic [7:0] sel_byte;

	assign slot_free = !out_valid_q || !out_stall;
	assign have = (mask_q != '0);
	assign emit = slot_free && have;
	assign low_bit = mask_q & (~mask_q + 1'b1);
	assign rest = mask_q & ~low_bit;
	assign last = (rest == '0);
	// refill on the last byte of a command so bytes flow without a gap
	assign pop = head_valid && (!have || (emit && last));

	assign width = 16'(cfg.right_col) - 16'(cfg.left_col) + 16'd1;
	assign height = 16'(cfg.bottom_row) - 16'(cfg.top_row) + 16'd1;

	always_comb begin
		idx = 4'd0;
		for (int i = cwpf_pkg::NUM_STEPS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				idx = 4'(i);
			end
		end
		case (int'(idx))
			cwpf_pkg::STEP_SYNC_A: sel_byte = cwpf_pkg::BYTE_AA;
			cwpf_pkg::STEP_SYNC_B: sel_byte = cwpf_pkg::BYTE_55;
			cwpf_pkg::STEP_TYPE: sel_byte = raw_q ? cwpf_pkg::TYPE_RAW : cwpf_pkg::TYPE_BIN;
			cwpf_pkg::STEP_W_HI: sel_byte = width[15:8];
			cwpf_pkg::STEP_W_LO: sel_byte = width[7:0];
			cwpf_pkg::STEP_H_HI: sel_byte = height[15:8];
			cwpf_pkg::STEP_H_LO: sel_byte = height[7:0];
			cwpf_pkg::STEP_PIX_HI: sel_byte = data_q[15:8];
			cwpf_pkg::STEP_PIX_LO: sel_byte = data_q[7:0];
			cwpf_pkg::STEP_TRL_A: sel_byte = cwpf_pkg::BYTE_55;
			cwpf_pkg::STEP_TRL_B: sel_byte = cwpf_pkg::BYTE_AA;
			default: sel_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= head_cmd.mask;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (slot_free) begin
				out_valid_q <= have;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head_cmd.data;
			raw_q <= head_cmd.raw;
		end
		if (emit) begin
			out_q.data_byte <= sel_byte;
			out_q.last_of_run <= last;
			out_q.frame_done <= (int'(idx) == cwpf_pkg::STEP_TRL_B);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

// ----- rtl/crop_window_pixel_framer_top.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  in_item   (pixel, col, row)
// out      out  out_valid/out_stall out_item (data_byte, last_of_run, frame_done)
// cfg      in   cfg_we             cfg_index, cfg_data
//
// Output bytes per pixel: a raw pixel gives two, a header seven more, a trailer two
// more, a binary pixel one per finished byte; pixels that make no byte never reach the
// back end. The output byte register is the limit.
// arst_n clears the command queue, the bit packer and the output valid, and loads the
// window registers with their defaults. in_stall rises only when the four-entry command
// queue is full; out_stall holds the byte register.
module crop_window_pixel_framer_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input cwpf_pkg::pix_in_t in_item,
	output logic out_valid,
	input logic out_stall,
	output cwpf_pkg::byte_out_t out_item,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [cwpf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	cwpf_pkg::cfg_t cfg_q;
	cwpf_pkg::cmd_t push_cmd, head_cmd;
	logic cmd_full, cmd_push, head_valid, cmd_pop;

	// Configuration registers; the user must write them only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_col <= cwpf_pkg::COORD_BITS'(650);
			cfg_q.top_row <= cwpf_pkg::COORD_BITS'(400);
			cfg_q.right_col <= cwpf_pkg::COORD_BITS'(1300);
			cfg_q.bottom_row <= cwpf_pkg::COORD_BITS'(650);
			cfg_q.send_raw <= 1'b0;
			cfg_q.bin_threshold <= 16'h8000;
		end else if (cfg_we) begin
			case (cwpf_pkg::cfg_idx_t'(cfg_index))
				cwpf_pkg::CFG_LEFT_COL: cfg_q.left_col <= cfg_data[cwpf_pkg::COORD_BITS-1:0];
				cwpf_pkg::CFG_TOP_ROW: cfg_q.top_row <= cfg_data[cwpf_pkg::COORD_BITS-1:0];
				cwpf_pkg::CFG_RIGHT_COL: cfg_q.right_col <= cfg_data[cwpf_pkg::COORD_BITS-1:0];
				cwpf_pkg::CFG_BOTTOM_ROW: cfg_q.bottom_row <= cfg_data[cwpf_pkg::COORD_BITS-1:0];
				cwpf_pkg::CFG_SEND_RAW: cfg_q.send_raw <= cfg_data[0];
				cwpf_pkg::CFG_BIN_THRESHOLD: cfg_q.bin_threshold <= cfg_data[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Front end: window test, header/trailer detection, bit packing.
	cwpf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd(push_cmd)
	);

	// Queue decouples input acceptance from byte serialization.
	cwpf_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.push_cmd(push_cmd),
		.full(cmd_full),
		.pop(cmd_pop),
		.head_valid(head_valid),
		.head_cmd(head_cmd)
	);

	// Back end: walk the byte slots of each command into the output register.
	cwpf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(cmd_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	// The closing trailer byte always ends its pixel's bytes.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.frame_done |-> out_item.last_of_run &&
			out_item.data_byte == cwpf_pkg::BYTE_AA)
		else $error("frame_done without last_of_run or trailer byte");

	// Bytes of one pixel follow each other with no gap.
	a_no_gap_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.last_of_run |=> out_valid)
		else $error("gap inside a pixel's byte run");

	// A full queue is never pushed.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_full |-> !cmd_push)
		else $error("command pushed into full queue");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;

	localparam int CYCLE_LIMIT = 200000;
	// margin after the last byte before a register write
	localparam int SETTLE_CYCLES = 20;
	localparam int BACKPRESSURE_CYCLES = 150;
	localparam int MAX_COORD = (1 << cwpf_pkg::COORD_BITS) - 1;

	typedef enum int {
		SCAN_CLEAN,
		SCAN_BROKEN,
		SCAN_NOISE
	} scan_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cwpf_pkg::pix_in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	cwpf_pkg::byte_out_t out_item;
	logic cfg_we = 1'b0;
	cwpf_pkg::cfg_idx_t cfg_index = cwpf_pkg::CFG_LEFT_COL;
	logic [cwpf_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	// shadow copy of the crop window registers and of the bit packer
	cwpf_pkg::cfg_t crop = '{left_col: 650, top_row: 400, right_col: 1300,
		bottom_row: 650, send_raw: 1'b0, bin_threshold: 16'h8000};
	logic [7:0] pack_bits = '0;

	cwpf_pkg::pix_in_t pending_pixels[$];
	cwpf_pkg::byte_out_t expected_bytes[$];
	cwpf_pkg::byte_out_t run_bytes[$];
	cwpf_pkg::byte_out_t seen_byte, due_byte;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic in_taken = 1'b0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int unsigned hold_left = 0;

	int unsigned pixels_queued = 0;
	int unsigned pixels_taken = 0;
	int unsigned window_pixels = 0;
	int unsigned bytes_checked = 0;
	int unsigned frames_done = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	crop_window_pixel_framer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endfunction

	function automatic void add_byte(logic [7:0] data, logic done);
		cwpf_pkg::byte_out_t b;
		b.data_byte = data;
		b.last_of_run = 1'b0;
		b.frame_done = done;
		run_bytes.push_back(b);
	endfunction

	// Work out the bytes one accepted pixel produces and append them to the
	// expected stream; the packer state advances here as in the block.
	function automatic void predict_pixel(cwpf_pkg::pix_in_t px);
		logic [15:0] w;
		logic [15:0] h;
		logic [2:0] place;
		cwpf_pkg::byte_out_t b;
		run_bytes.delete();
		if (px.col < crop.left_col || px.col > crop.right_col ||
				px.row < crop.top_row || px.row > crop.bottom_row) begin
			return;
		end
		// top-left corner opens the frame with the header
		if (px.col == crop.left_col && px.row == crop.top_row) begin
			w = 16'(crop.right_col) - 16'(crop.left_col) + 16'd1;
			h = 16'(crop.bottom_row) - 16'(crop.top_row) + 16'd1;
			add_byte(cwpf_pkg::BYTE_AA, 1'b0);
			add_byte(cwpf_pkg::BYTE_55, 1'b0);
			add_byte(crop.send_raw ? cwpf_pkg::TYPE_RAW : cwpf_pkg::TYPE_BIN, 1'b0);
			add_byte(w[15:8], 1'b0);
			add_byte(w[7:0], 1'b0);
			add_byte(h[15:8], 1'b0);
			add_byte(h[7:0], 1'b0);
		end
		if (crop.send_raw) begin
			add_byte(px.pixel[15:8], 1'b0);
			add_byte(px.pixel[7:0], 1'b0);
		end else begin
			// MSB first; place 0 starts a fresh byte, row end flushes a short one
			place = 3'(px.col - crop.left_col);
			if (place == 3'd0) begin
				pack_bits = '0;
			end
			if (px.pixel > crop.bin_threshold) begin
				pack_bits[3'd7 - place] = 1'b1;
			end
			if (place == 3'd7 || px.col == crop.right_col) begin
				add_byte(pack_bits, 1'b0);
				pack_bits = '0;
			end
		end
		// bottom-right corner closes the frame
		if (px.col == crop.right_col && px.row == crop.bottom_row) begin
			add_byte(cwpf_pkg::BYTE_55, 1'b0);
			add_byte(cwpf_pkg::BYTE_AA, 1'b1);
		end
		if (run_bytes.size() != 0) begin
			b = run_bytes[run_bytes.size() - 1];
			b.last_of_run = 1'b1;
			run_bytes[run_bytes.size() - 1] = b;
		end
		foreach (run_bytes[i]) begin
			expected_bytes.push_back(run_bytes[i]);
		end
	endfunction

	function automatic void push_pix(logic [15:0] pix, int col, int row);
		cwpf_pkg::pix_in_t px;
		px.pixel = pix;
		px.col = cwpf_pkg::coord_t'(col);
		px.row = cwpf_pkg::coord_t'(row);
		pending_pixels.push_back(px);
		pixels_queued++;
		if (px.col >= crop.left_col && px.col <= crop.right_col &&
				px.row >= crop.top_row && px.row <= crop.bottom_row) begin
			window_pixels++;
		end
	endfunction

	// favor values right at the threshold and the ends of the range
	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(5))
			0: pick_pixel = crop.bin_threshold;
			1: pick_pixel = crop.bin_threshold + 16'd1;
			2: pick_pixel = 16'h0000;
			3: pick_pixel = 16'hFFFF;
			default: pick_pixel = 16'($urandom);
		endcase
	endfunction

	// Write one register; keep the shadow copy masked the way the block masks.
	task automatic write_reg(cwpf_pkg::cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cwpf_pkg::CFG_LEFT_COL: crop.left_col = cwpf_pkg::coord_t'(val);
			cwpf_pkg::CFG_TOP_ROW: crop.top_row = cwpf_pkg::coord_t'(val);
			cwpf_pkg::CFG_RIGHT_COL: crop.right_col = cwpf_pkg::coord_t'(val);
			cwpf_pkg::CFG_BOTTOM_ROW: crop.bottom_row = cwpf_pkg::coord_t'(val);
			cwpf_pkg::CFG_SEND_RAW: crop.send_raw = val[0];
			cwpf_pkg::CFG_BIN_THRESHOLD: crop.bin_threshold = val;
			default: ;
		endcase
	endtask

	// Load the whole window; junk in the unused upper bits must be dropped.
	task automatic set_window(int l, int t, int r, int b, logic raw, logic [15:0] thr);
		write_reg(cwpf_pkg::CFG_LEFT_COL, 16'(l) | (16'($urandom) << cwpf_pkg::COORD_BITS));
		write_reg(cwpf_pkg::CFG_TOP_ROW, 16'(t) | (16'($urandom) << cwpf_pkg::COORD_BITS));
		write_reg(cwpf_pkg::CFG_RIGHT_COL, 16'(r) | (16'($urandom) << cwpf_pkg::COORD_BITS));
		write_reg(cwpf_pkg::CFG_BOTTOM_ROW, 16'(b) | (16'($urandom) << cwpf_pkg::COORD_BITS));
		write_reg(cwpf_pkg::CFG_SEND_RAW, {15'($urandom), raw});
		write_reg(cwpf_pkg::CFG_BIN_THRESHOLD, thr);
	endtask

	// Hold until every queued pixel is taken and every byte has come out,
	// then let the pipeline run empty.
	task automatic settle();
		@(negedge clk);
		while (pixels_queued != pixels_taken || expected_bytes.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Raster over the current window, sometimes with a one-pixel border of
	// pixels the block must drop.
	task automatic scan_window(scan_style_t style);
		int r0, r1, c0, c1;
		int unsigned roll;
		@(posedge clk);
		r0 = crop.top_row;
		r1 = crop.bottom_row;
		c0 = crop.left_col;
		c1 = crop.right_col;
		if ($urandom_range(1) == 1) begin
			if (r0 > 0) r0--;
			if (r1 < MAX_COORD) r1++;
			if (c0 > 0) c0--;
			if (c1 < MAX_COORD) c1++;
		end
		for (int r = r0; r <= r1; r++) begin
			for (int c = c0; c <= c1; c++) begin
				roll = $urandom_range(99);
				if (style == SCAN_NOISE && roll < 20) begin
					push_pix(16'($urandom), $urandom_range(MAX_COORD),
						$urandom_range(MAX_COORD));
				end
				// broken scans drop or repeat pixels
				if (!(style == SCAN_BROKEN && roll < 15)) begin
					push_pix(pick_pixel(), c, r);
					if (style == SCAN_BROKEN && roll >= 88) begin
						push_pix(pick_pixel(), c, r);
					end
				end
			end
		end
	endtask

	// Random windows until about target pixel transactions have been queued.
	task automatic random_frames(int unsigned target);
		int unsigned w, h, l, t, roll, start;
		logic [15:0] thr;
		start = pixels_queued;
		while (pixels_queued - start < target) begin
			if ($urandom_range(7) == 0) begin
				w = $urandom_range(12, 20);
				h = 1;
			end else begin
				w = $urandom_range(1, 10);
				h = $urandom_range(1, 3);
			end
			l = $urandom_range(0, MAX_COORD + 1 - w);
			t = $urandom_range(0, MAX_COORD + 1 - h);
			roll = $urandom_range(9);
			thr = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
			settle();
			set_window(l, t, l + w - 1, t + h - 1, 1'($urandom_range(1)), thr);
			roll = $urandom_range(99);
			scan_window(roll < 70 ? SCAN_CLEAN : roll < 85 ? SCAN_BROKEN : SCAN_NOISE);
		end
	endtask

	// Driver: offer the next pixel once the current transaction is taken;
	// idle at random between transactions, never during one.
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (arst_n && pending_pixels.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				in_item <= pending_pixels.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= BACKPRESSURE_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Monitor: check each output transaction against the oldest expected
	// byte, and predict the bytes of each accepted pixel.
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			seen_byte = out_item;
			if (expected_bytes.size() == 0) begin
				flag_error($sformatf("unexpected byte %02h last %b done %b",
					seen_byte.data_byte, seen_byte.last_of_run, seen_byte.frame_done));
			end else begin
				due_byte = expected_bytes.pop_front();
				if (seen_byte.data_byte !== due_byte.data_byte ||
						seen_byte.last_of_run !== due_byte.last_of_run ||
						seen_byte.frame_done !== due_byte.frame_done) begin
					flag_error($sformatf(
						"byte exp %02h/%b/%b got %02h/%b/%b (data/last/done)",
						due_byte.data_byte, due_byte.last_of_run, due_byte.frame_done,
						seen_byte.data_byte, seen_byte.last_of_run, seen_byte.frame_done));
				end
				bytes_checked++;
				if (seen_byte.frame_done) frames_done++;
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			predict_pixel(in_item);
			pixels_taken++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct <= 27;
		recv_idle_pct <= 67;

		// reset defaults: one out-of-window pixel, the header of the 651 x 251
		// window, then the bottom-right corner with a short packed byte
		@(posedge clk);
		push_pix(16'h8001, 0, 0);
		push_pix(16'hFFFF, 650, 400);
		push_pix(16'h8000, 1300, 650);
		settle();

		// full coordinate range in raw mode: width and height of 4096
		set_window(0, 0, MAX_COORD, MAX_COORD, 1'b1, 16'h8000);
		@(posedge clk);
		push_pix(16'hFFFF, 0, 0);
		push_pix(16'h0001, MAX_COORD, 0);
		push_pix(16'h0000, MAX_COORD, MAX_COORD);
		settle();

		// single-pixel raw window: the longest run, header + pixel + trailer
		set_window(0, 0, 0, 0, 1'b1, 16'h8000);
		@(posedge clk);
		push_pix(16'h1234, 0, 0);
		push_pix(16'hABCD, 1, 0);
		push_pix(16'hABCD, 0, 1);
		settle();

		// single-pixel binary window at the far corner
		set_window(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 1'b0, 16'h1234);
		@(posedge clk);
		push_pix(16'h1235, MAX_COORD, MAX_COORD);
		settle();

		// ten-pixel binary row; change threshold and mode between pixels
		set_window(100, 5, 109, 5, 1'b0, 16'h0000);
		@(posedge clk);
		push_pix(16'h0000, 100, 5);
		push_pix(16'h0001, 101, 5);
		push_pix(16'hFFFF, 102, 5);
		push_pix(16'h0000, 103, 5);
		settle();
		write_reg(cwpf_pkg::CFG_BIN_THRESHOLD, 16'hFFFF);
		@(posedge clk);
		push_pix(16'hFFFF, 104, 5);
		push_pix(16'hFFFE, 105, 5);
		settle();
		write_reg(cwpf_pkg::CFG_SEND_RAW, 16'h0001);
		@(posedge clk);
		push_pix(16'hA5C3, 106, 5);
		settle();
		write_reg(cwpf_pkg::CFG_SEND_RAW, 16'h0000);
		write_reg(cwpf_pkg::CFG_BIN_THRESHOLD, 16'h8000);
		@(posedge clk);
		push_pix(16'h8001, 107, 5);
		push_pix(16'h8000, 108, 5);
		push_pix(16'h8001, 109, 5);
		settle();

		// corners out of order: the window is empty, nothing comes out
		set_window(10, 0, 5, 0, 1'b1, 16'h8000);
		@(posedge clk);
		push_pix(16'h1111, 7, 0);
		push_pix(16'h2222, 10, 0);
		push_pix(16'h3333, 5, 0);
		settle();
		set_window(0, 9, MAX_COORD, 3, 1'b0, 16'h0000);
		@(posedge clk);
		push_pix(16'hFFFF, 0, 9);
		push_pix(16'hFFFF, 0, 3);

		random_frames(15);

		settle();
		send_idle_pct <= 67;
		recv_idle_pct <= 27;
		random_frames(15);

		// no idling; hold the output off while a raw row streams in
		// so the command queue fills and the input stalls
		settle();
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		set_window($urandom_range(0, MAX_COORD - 11), $urandom_range(0, MAX_COORD),
			0, 0, 1'b1, 16'($urandom));
		write_reg(cwpf_pkg::CFG_RIGHT_COL, 16'(crop.left_col) + 16'd11);
		write_reg(cwpf_pkg::CFG_BOTTOM_ROW, 16'(crop.top_row));
		hold_req <= ~hold_req;
		scan_window(SCAN_CLEAN);
		random_frames(5);

		settle();
		$display("covered %0d pixel transactions (%0d inside a window), %0d bytes checked",
			pixels_taken, window_pixels, bytes_checked);
		$display("in %0d complete frames over binary and raw modes and several windows",
			frames_done);
		if (error_count == 0 && expected_bytes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d bytes never seen", error_count,
				expected_bytes.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
